// ===== hdl/wvd_pkg.sv =====
// Package for the wind vane direction decoder: widths, register codes,
// the sector resistance table and the candidate type of the minimum search.
// No dependencies.
`default_nettype none

package wvd_pkg;

	// Converter and sector configuration.
	localparam int ADC_BITS = 12;
	localparam int SECTORS  = 16;
	localparam int TABLE_LEN = 16;

	// Field widths.
	localparam int R_W    = 16;
	localparam int OFS_W  = 12;
	localparam int DIR_W  = 12;
	localparam int IDX_W  = 4;
	localparam int OHMS_W = 28;
	localparam int CIDX_W = 4;

	// Divider geometry: numerator is code times resistor, divisor is full scale minus code.
	localparam int NUM_W      = ADC_BITS + R_W;
	localparam int DIV_W      = ADC_BITS + 1;
	localparam int DIV_STEP   = 4;
	localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;
	localparam int NUM_PAD    = DIV_STAGES * DIV_STEP;

	// Direction arithmetic in tenths of a degree.
	localparam logic [DIR_W-1:0] STEP_TENTHS = DIR_W'(225);
	localparam logic [DIR_W:0]   FULL_TURN   = (DIR_W + 1)'(3600);

	// Register reset values.
	localparam logic [R_W-1:0]   SERIES_R_RESET = R_W'(4700);
	localparam logic [OFS_W-1:0] OFFSET_RESET   = '0;

	// Configuration register indexes.
	typedef enum logic [CIDX_W-1:0] {
		CFG_SERIES_R = 4'd0,
		CFG_OFFSET   = 4'd1
	} cfg_reg_t;

	// Nominal vane resistance of each sector, north first.
	localparam logic [OHMS_W-1:0] SECTOR_OHMS [TABLE_LEN] = '{
		28'd33000, 28'd6570, 28'd8200, 28'd891, 28'd1000, 28'd688, 28'd2200, 28'd1410,
		28'd3900, 28'd3140, 28'd16000, 28'd14120, 28'd120000, 28'd42120, 28'd64900,
		28'd21880
	};

	// One candidate of the nearest-entry search.
	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [OHMS_W-1:0] err;
	} cand_t;

	// Keep the left candidate unless the right one is strictly better, so the
	// lowest index wins on equal error.
	function automatic cand_t pick_min(input cand_t a, input cand_t b);
		return (b.err < a.err) ? b : a;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/wind_vane_direction_decoder_core.sv =====
// Top level of the wind vane direction decoder: configuration registers,
// product stage, divider and matcher. Depends on wvd_pkg, wvd_divider, wvd_matcher.
`default_nettype none

// Converts one 12-bit converter sample per clock, while the input is not stalled, into
// vane resistance, nearest sector and direction in tenths of a degree. The pipeline
// takes a new item every cycle unless in_stall is high; each item passes the product
// register for the code-times-resistor product, seven divider stages that each retire
// four quotient bits, and four stages of error, minimum search and direction. Bubbles
// inside are squeezed out when the output stalls, so input is stalled only when
// every stage is full. Configuration writes are always ready and take effect at
// once; write them only while no item is in flight.
module wind_vane_direction_decoder_core
	import wvd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [ADC_BITS-1:0] adc_code,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [DIR_W-1:0]         direction_tenths,
	output logic [IDX_W-1:0]         sector_index,
	output logic [OHMS_W-1:0]        vane_ohms,
	output logic [OHMS_W-1:0]        match_error_ohms,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CIDX_W-1:0]   cfg_index,
	input  wire logic [R_W-1:0]      cfg_data
);

	logic [R_W-1:0]    series_r_q;
	logic [OFS_W-1:0]  offset_q;

	logic              vld_s1;
	logic              adv_s1;
	logic [NUM_W-1:0]  num_s1;
	logic [DIV_W-1:0]  den_s1;

	logic              div_ready;
	logic              div_valid;
	logic [OHMS_W-1:0] div_quo;
	logic              match_ready;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			series_r_q <= SERIES_R_RESET;
			offset_q   <= OFFSET_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SERIES_R: series_r_q <= cfg_data;
				CFG_OFFSET:   offset_q   <= cfg_data[OFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Product stage: numerator and divisor of the resistance.
	assign adv_s1   = !vld_s1 || div_ready;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			num_s1 <= NUM_W'(adc_code) * NUM_W'(series_r_q);
			den_s1 <= DIV_W'(1 << ADC_BITS) - {1'b0, adc_code};
		end
	end

	// Resistance divider.
	wvd_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s1),
		.in_ready  (div_ready),
		.numer     (num_s1),
		.denom     (den_s1),
		.out_valid (div_valid),
		.out_ready (match_ready),
		.quotient  (div_quo)
	);

	// Sector match and direction.
	wvd_matcher u_matcher (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (div_valid),
		.in_ready         (match_ready),
		.ohms             (div_quo),
		.offset           (offset_q),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.direction_tenths (direction_tenths),
		.sector_index     (sector_index),
		.vane_ohms        (vane_ohms),
		.match_error_ohms (match_error_ohms)
	);

`ifndef SYNTHESIS
	// With nothing waiting at the output the whole pipeline can move.
	assert property (@(posedge clk) disable iff (!arst_n) !out_valid |-> !in_stall)
		else $error("input stalled while output is empty");

	// The reported error matches the reported sector and resistance.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_error_ohms == ((vane_ohms >= SECTOR_OHMS[sector_index])
			? (vane_ohms - SECTOR_OHMS[sector_index])
			: (SECTOR_OHMS[sector_index] - vane_ohms)))
		else $error("match error inconsistent with sector");

	// A legal offset always gives a direction below a full turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (offset_q < OFS_W'(3600)) |-> direction_tenths < DIR_W'(3600))
		else $error("direction not wrapped");
`endif

endmodule

`default_nettype wire

// ===== hdl/wvd_divider.sv =====
// Pipelined restoring divider, four quotient bits per stage.
// Depends on wvd_pkg.
`default_nettype none

module wvd_divider
	import wvd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [NUM_W-1:0]  numer,
	input  wire logic [DIV_W-1:0]  denom,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [OHMS_W-1:0]      quotient
);

	// Stage registers.
	logic                vld_s [DIV_STAGES];
	logic [DIV_W-1:0]    rem_s [DIV_STAGES];
	logic [DIV_W-1:0]    dvs_s [DIV_STAGES];
	logic [NUM_PAD-1:0]  num_s [DIV_STAGES];
	logic [NUM_PAD-1:0]  quo_s [DIV_STAGES];

	// adv[k] is high when stage k may load; the last entry is the downstream ready.
	logic                adv [DIV_STAGES+1];

	assign adv[DIV_STAGES] = out_ready;
	assign in_ready        = adv[0];

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		logic               vld_in;
		logic [DIV_W-1:0]   rem_in;
		logic [DIV_W-1:0]   dvs_in;
		logic [NUM_PAD-1:0] num_in;
		logic [NUM_PAD-1:0] quo_in;
		logic [DIV_W-1:0]   rem_nx;
		logic [NUM_PAD-1:0] num_nx;
		logic [NUM_PAD-1:0] quo_nx;

		// Stage input comes from the ports for the first stage, else from the previous one.
		if (k == 0) begin : g_first
			assign vld_in = in_valid;
			assign rem_in = '0;
			assign dvs_in = denom;
			assign num_in = NUM_PAD'(numer);
			assign quo_in = '0;
		end else begin : g_next
			assign vld_in = vld_s[k-1];
			assign rem_in = rem_s[k-1];
			assign dvs_in = dvs_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
		end

		// A stage loads when it is empty or its content moves on.
		assign adv[k] = !vld_s[k] || adv[k+1];

		// Four restoring steps: shift in a numerator bit, subtract the divisor if it fits.
		always_comb begin
			logic [DIV_W:0] trial;
			rem_nx = rem_in;
			num_nx = num_in;
			quo_nx = quo_in;
			for (int b = 0; b < DIV_STEP; b++) begin
				trial  = {rem_nx, num_nx[NUM_PAD-1]};
				num_nx = num_nx << 1;
				quo_nx = quo_nx << 1;
				if (trial >= {1'b0, dvs_in}) begin
					rem_nx    = DIV_W'(trial - {1'b0, dvs_in});
					quo_nx[0] = 1'b1;
				end else begin
					rem_nx = trial[DIV_W-1:0];
				end
			end
		end

		// Valid bit travels with the data.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && vld_in) begin
				rem_s[k] <= rem_nx;
				dvs_s[k] <= dvs_in;
				num_s[k] <= num_nx;
				quo_s[k] <= quo_nx;
			end
		end
	end

	assign out_valid = vld_s[DIV_STAGES-1];
	assign quotient  = quo_s[DIV_STAGES-1][OHMS_W-1:0];

endmodule

`default_nettype wire

// ===== hdl/wvd_matcher.sv =====
// Nearest sector search and direction computation, four register stages,
// the last of which is the output register. Depends on wvd_pkg.
`default_nettype none

module wvd_matcher
	import wvd_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OHMS_W-1:0] ohms,
	input  wire logic [OFS_W-1:0]  offset,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [DIR_W-1:0]       direction_tenths,
	output logic [IDX_W-1:0]       sector_index,
	output logic [OHMS_W-1:0]      vane_ohms,
	output logic [OHMS_W-1:0]      match_error_ohms
);

	logic              vld_s1, vld_s2, vld_s3, vld_s4;
	logic              adv_s1, adv_s2, adv_s3, adv_s4;
	logic [OHMS_W-1:0] ohms_s1, ohms_s2, ohms_s3, ohms_s4;
	logic [OHMS_W-1:0] err_s1 [TABLE_LEN];
	cand_t             grp_s2 [4];
	cand_t             best_s3;
	logic [IDX_W-1:0]  idx_s4;
	logic [OHMS_W-1:0] err_s4;
	logic [DIR_W-1:0]  dir_s4;

	logic [OHMS_W-1:0] err_nx [TABLE_LEN];
	cand_t             grp_nx [4];
	cand_t             best_nx;
	logic [DIR_W:0]    dir_sum;
	logic [DIR_W-1:0]  dir_nx;

	// Ready chain from the output back to the input.
	assign adv_s4   = !vld_s4 || !out_stall;
	assign adv_s3   = !vld_s3 || adv_s4;
	assign adv_s2   = !vld_s2 || adv_s3;
	assign adv_s1   = !vld_s1 || adv_s2;
	assign in_ready = adv_s1;

	// Absolute error against each table entry; unused entries can never win.
	for (genvar i = 0; i < TABLE_LEN; i++) begin : g_err
		if (i < SECTORS) begin : g_used
			assign err_nx[i] = (ohms >= SECTOR_OHMS[i]) ? (ohms - SECTOR_OHMS[i])
				: (SECTOR_OHMS[i] - ohms);
		end else begin : g_unused
			assign err_nx[i] = '1;
		end
	end

	// First reduction: sixteen errors down to four candidates.
	always_comb begin
		cand_t lo;
		cand_t hi;
		for (int g = 0; g < 4; g++) begin
			lo = pick_min('{idx: IDX_W'(4*g),   err: err_s1[4*g]},
				'{idx: IDX_W'(4*g+1), err: err_s1[4*g+1]});
			hi = pick_min('{idx: IDX_W'(4*g+2), err: err_s1[4*g+2]},
				'{idx: IDX_W'(4*g+3), err: err_s1[4*g+3]});
			grp_nx[g] = pick_min(lo, hi);
		end
	end

	// Second reduction: four candidates down to the match.
	assign best_nx = pick_min(pick_min(grp_s2[0], grp_s2[1]), pick_min(grp_s2[2], grp_s2[3]));

	// Direction is sector times the step plus the offset, wrapped once.
	always_comb begin
		dir_sum = (DIR_W + 1)'(best_s3.idx * STEP_TENTHS) + (DIR_W + 1)'(offset);
		if (dir_sum >= FULL_TURN) begin
			dir_nx = DIR_W'(dir_sum - FULL_TURN);
		end else begin
			dir_nx = dir_sum[DIR_W-1:0];
		end
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				vld_s1 <= in_valid;
			end
			if (adv_s2) begin
				vld_s2 <= vld_s1;
			end
			if (adv_s3) begin
				vld_s3 <= vld_s2;
			end
			if (adv_s4) begin
				vld_s4 <= vld_s3;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			ohms_s1 <= ohms;
			err_s1  <= err_nx;
		end
		if (adv_s2 && vld_s1) begin
			ohms_s2 <= ohms_s1;
			grp_s2  <= grp_nx;
		end
		if (adv_s3 && vld_s2) begin
			ohms_s3 <= ohms_s2;
			best_s3 <= best_nx;
		end
		if (adv_s4 && vld_s3) begin
			ohms_s4 <= ohms_s3;
			idx_s4  <= best_s3.idx;
			err_s4  <= best_s3.err;
			dir_s4  <= dir_nx;
		end
	end

	assign out_valid        = vld_s4;
	assign direction_tenths = dir_s4;
	assign sector_index     = idx_s4;
	assign vane_ohms        = ohms_s4;
	assign match_error_ohms = err_s4;

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for wind_vane_direction_decoder_core. A small class predicts each
// heading from the accepted sample and the register settings; plain tasks drive the block.
// Depends on wvd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb_top
	import wvd_pkg::*;
;

	localparam int unsigned DEG_STEP_TENTHS = 225;
	localparam int unsigned TURN_TENTHS     = 3600;
	localparam int          DRAIN_CYCLES    = 20;
	localparam int          PRINT_CAP       = 200;

	// One expected result, with the sample that caused it.
	typedef struct packed {
		logic [ADC_BITS-1:0] code;
		logic [DIR_W-1:0]    dir;
		logic [IDX_W-1:0]    sector;
		logic [OHMS_W-1:0]   ohms;
		logic [OHMS_W-1:0]   err;
	} heading_t;

	typedef enum int {HOLD_NONE, HOLD_LIGHT, HOLD_HEAVY, HOLD_PERIODIC} hold_style_t;

	// Predicts headings from accepted samples and checks the results in order.
	class heading_checker;
		logic [R_W-1:0]   series_ohms;
		logic [OFS_W-1:0] offset;
		longint unsigned  nominal_ohms [TABLE_LEN];
		heading_t         pending_headings [$];
		int               mismatch_count;
		int               samples_noted;
		int               headings_checked;
		int               writes_taken;
		int               writes_ignored;

		function new();
			series_ohms = 16'd4700;
			offset = '0;
			nominal_ohms = '{33000, 6570, 8200, 891, 1000, 688, 2200, 1410,
				3900, 3140, 16000, 14120, 120000, 42120, 64900, 21880};
		endfunction

		function void report_mismatch(string what);
			if (mismatch_count < PRINT_CAP)
				$display("tb_top: mismatch at %0t: %s", $time, what);
			mismatch_count++;
		endfunction

		function longint unsigned ohms_gap(longint unsigned a, longint unsigned b);
			return (a >= b) ? a - b : b - a;
		endfunction

		// Divider equation with the reference voltage cancelled, truncated to whole ohms.
		function longint unsigned vane_resistance(logic [ADC_BITS-1:0] code);
			longint unsigned full;
			full = longint'(1) << ADC_BITS;
			return (longint'(code) * longint'(series_ohms)) / (full - longint'(code));
		endfunction

		// Sample that lands closest to a sector's nominal resistance.
		function logic [ADC_BITS-1:0] sector_center_code(int k);
			longint unsigned t;
			longint unsigned c;
			t = nominal_ohms[k];
			c = ((longint'(1) << ADC_BITS) * t + (t + series_ohms) / 2) / (t + series_ohms);
			if (c > (longint'(1) << ADC_BITS) - 1)
				c = (longint'(1) << ADC_BITS) - 1;
			return ADC_BITS'(c);
		endfunction

		// True when two or more table entries share the smallest error.
		function bit is_tie(logic [ADC_BITS-1:0] code);
			longint unsigned ohms;
			longint unsigned least;
			int hits;
			ohms = vane_resistance(code);
			least = ohms_gap(ohms, nominal_ohms[0]);
			for (int i = 1; i < SECTORS; i++)
				if (ohms_gap(ohms, nominal_ohms[i]) < least)
					least = ohms_gap(ohms, nominal_ohms[i]);
			hits = 0;
			for (int i = 0; i < SECTORS; i++)
				if (ohms_gap(ohms, nominal_ohms[i]) == least)
					hits++;
			return hits > 1;
		endfunction

		// Nearest sector by absolute error; the lowest index wins a tie.
		function heading_t predict_heading(logic [ADC_BITS-1:0] code);
			heading_t h;
			longint unsigned ohms;
			longint unsigned best_err;
			int unsigned best;
			int unsigned dir;
			ohms = vane_resistance(code);
			best = 0;
			best_err = ohms_gap(ohms, nominal_ohms[0]);
			for (int i = 1; i < SECTORS; i++) begin
				if (ohms_gap(ohms, nominal_ohms[i]) < best_err) begin
					best_err = ohms_gap(ohms, nominal_ohms[i]);
					best = i;
				end
			end
			// The offset can exceed a full turn, so one wrap may leave more than 3599.
			dir = best * DEG_STEP_TENTHS + offset;
			if (dir >= TURN_TENTHS)
				dir -= TURN_TENTHS;
			h.code = code;
			h.dir = DIR_W'(dir);
			h.sector = IDX_W'(best);
			h.ohms = OHMS_W'(ohms);
			h.err = OHMS_W'(best_err);
			return h;
		endfunction

		function void note_write(logic [CIDX_W-1:0] index, logic [R_W-1:0] data);
			case (index)
				CFG_SERIES_R: series_ohms = data;
				CFG_OFFSET:   offset = data[OFS_W-1:0];
				default:      writes_ignored++;
			endcase
			writes_taken++;
		endfunction

		function void note_sample(logic [ADC_BITS-1:0] code);
			pending_headings.push_back(predict_heading(code));
			samples_noted++;
		endfunction

		function void check_heading(logic [DIR_W-1:0] dir, logic [IDX_W-1:0] sector,
				logic [OHMS_W-1:0] ohms, logic [OHMS_W-1:0] err);
			heading_t want;
			if (pending_headings.size() == 0) begin
				report_mismatch("result with no sample pending");
				return;
			end
			want = pending_headings.pop_front();
			headings_checked++;
			if (dir !== want.dir)
				report_mismatch($sformatf("sample %0d direction_tenths got %0d want %0d",
					want.code, dir, want.dir));
			if (sector !== want.sector)
				report_mismatch($sformatf("sample %0d sector_index got %0d want %0d",
					want.code, sector, want.sector));
			if (ohms !== want.ohms)
				report_mismatch($sformatf("sample %0d vane_ohms got %0d want %0d",
					want.code, ohms, want.ohms));
			if (err !== want.err)
				report_mismatch($sformatf("sample %0d match_error_ohms got %0d want %0d",
					want.code, err, want.err));
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [ADC_BITS-1:0] adc_code;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [DIR_W-1:0]    direction_tenths;
	logic [IDX_W-1:0]    sector_index;
	logic [OHMS_W-1:0]   vane_ohms;
	logic [OHMS_W-1:0]   match_error_ohms;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [CIDX_W-1:0]   cfg_index;
	logic [R_W-1:0]      cfg_data;

	heading_checker sb;
	int             burst_left = 0;
	int unsigned    hold_tick = 0;
	hold_style_t    hold_style = HOLD_NONE;

	wind_vane_direction_decoder_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.adc_code         (adc_code),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.direction_tenths (direction_tenths),
		.sector_index     (sector_index),
		.vane_ohms        (vane_ohms),
		.match_error_ohms (match_error_ohms),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// Receiver stall pattern: a randomly chosen style, redrawn periodically, sets out_stall.
	always @(negedge clk) begin
		hold_tick <= hold_tick + 1;
		if (hold_tick % 48 == 0)
			hold_style <= hold_style_t'($urandom_range(3, 0));
		case (hold_style)
			HOLD_NONE:  out_stall <= 1'b0;
			HOLD_LIGHT: out_stall <= ($urandom_range(3, 0) == 0);
			HOLD_HEAVY: out_stall <= ($urandom_range(9, 0) < 7);
			default:    out_stall <= (hold_tick % 5 < 2);
		endcase
	end

	// Check every result that leaves the block.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_heading(direction_tenths, sector_index, vane_ohms, match_error_ohms);
	end

	// Send one item; the sender works in bursts with random gaps in between.
	task automatic push_sample(input logic [ADC_BITS-1:0] code);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(24, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				adc_code <= ADC_BITS'($urandom);
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		adc_code <= code;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_sample(code);
	endtask

	// Random samples: uniform, near a sector's nominal value, or near the ends of the range.
	task automatic run_random(input int count);
		int c;
		repeat (count) begin
			case ($urandom_range(3, 0))
				0, 1: c = $urandom_range((1 << ADC_BITS) - 1, 0);
				2: begin
					c = int'(sb.sector_center_code($urandom_range(SECTORS - 1, 0)));
					c = c + $urandom_range(16, 0) - 8;
					if (c < 0) c = 0;
					if (c > (1 << ADC_BITS) - 1) c = (1 << ADC_BITS) - 1;
				end
				default: c = ($urandom_range(1, 0) == 0) ? $urandom_range(15, 0)
					: (1 << ADC_BITS) - 1 - $urandom_range(15, 0);
			endcase
			push_sample(ADC_BITS'(c));
		end
	endtask

	task automatic write_reg(input logic [CIDX_W-1:0] index, input logic [R_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.note_write(index, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Stop sending and wait until every expected result has come out.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.pending_headings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [CIDX_W-1:0] spare_index();
		return CIDX_W'($urandom_range((1 << CIDX_W) - 1, int'(CFG_OFFSET) + 1));
	endfunction

	initial begin
		logic [ADC_BITS-1:0] tie_codes [$];
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		adc_code = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_SERIES_R;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: range ends, each sector's center and equal-error samples.
		push_sample('0);
		push_sample('1);
		push_sample(ADC_BITS'(1));
		push_sample(ADC_BITS'((1 << ADC_BITS) - 2));
		push_sample(ADC_BITS'(1 << (ADC_BITS - 1)));
		for (int k = 0; k < SECTORS; k++)
			push_sample(sb.sector_center_code(k));
		for (int c = 0; c < (1 << ADC_BITS) && tie_codes.size() < 4; c++)
			if (sb.is_tie(ADC_BITS'(c)))
				tie_codes.push_back(ADC_BITS'(c));
		foreach (tie_codes[i])
			push_sample(tie_codes[i]);
		run_random(70);
		settle();

		// Zero series resistor: every sample reads as zero ohms.
		write_reg(CFG_SERIES_R, '0);
		write_reg(CFG_OFFSET, 16'd100);
		run_random(40);
		settle();

		// Largest resistor and largest in-range offset.
		write_reg(CFG_SERIES_R, '1);
		write_reg(CFG_OFFSET, 16'd3599);
		run_random(80);
		settle();

		// Smallest nonzero resistor; offset beyond a full turn; a write to an unused index.
		write_reg(CIDX_W'((1 << CIDX_W) - 1), 16'h1234);
		write_reg(CFG_SERIES_R, 16'd1);
		write_reg(CFG_OFFSET, '1);
		run_random(80);
		settle();

		write_reg(CFG_SERIES_R, 16'd4700);
		write_reg(CFG_OFFSET, 16'd1800);
		write_reg(spare_index(), R_W'($urandom));
		run_random(80);
		settle();

		repeat (3) begin
			write_reg(CFG_SERIES_R, R_W'($urandom));
			write_reg(CFG_OFFSET, R_W'($urandom));
			if ($urandom_range(1, 0) == 1)
				write_reg(spare_index(), R_W'($urandom));
			run_random(70);
			settle();
		end

		$display("tb_top: %0d samples sent, %0d headings checked, %0d of them tie cases",
			sb.samples_noted, sb.headings_checked, tie_codes.size());
		$display("tb_top: %0d register writes, %0d to unused indexes", sb.writes_taken,
			sb.writes_ignored);
		if (sb.mismatch_count == 0 && sb.pending_headings.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
